// ===== rtl/core/fdr_pkg.sv =====
// shared types and constants for the dielectric fresnel reflectance pipeline
// no dependencies
package fdr_pkg;

  localparam int ETA_W   = 16;  // unsigned q4.12 index
  localparam int COS_W   = 17;  // signed q2.15 cosine
  localparam int C_W     = 16;  // cosine magnitude, q1.15
  localparam int REFL_W  = 16;  // unsigned q1.15 reflectance
  localparam int S2_W    = 31;  // sin^2, q30
  localparam int PROD_W  = 32;  // 16x16 products
  localparam int NUM_W   = 62;  // transmitted cos^2 dividend
  localparam int QUO_W   = 31;  // quotients, q30
  localparam int RES_W   = 32;  // square root partial result
  localparam int RDD_W   = 63;  // ratio dividend
  localparam int SQR_W   = 61;  // squared ratio
  localparam int SQRT_STEPS = 16;

  localparam logic [REFL_W-1:0] ONE_Q15 = 16'd32768;
  localparam logic [QUO_W-1:0]  ONE_Q30 = 31'h4000_0000;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ETA_INC = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ETA_TRN = 1'b1;

  typedef struct packed {
    logic             tir;
    logic [ETA_W-1:0] ni;
    logic [ETA_W-1:0] nt;
    logic [C_W-1:0]   c;
  } fdr_geo_t;

  localparam int GEO_W = $bits(fdr_geo_t);

endpackage

// ===== rtl/core/fdr_div_cell.sv =====
// one restoring divide cell: settles a single quotient bit and passes the beat on
// uses no package
module fdr_div_cell #(
  parameter int REM_W = 62,
  parameter int DVS_W = 32,
  parameter int QUO_W = 31,
  parameter int SB_W  = 1,
  parameter int STEP  = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             vld_i,
  input  logic [REM_W-1:0] rem_i,
  input  logic [DVS_W-1:0] dvs_i,
  input  logic [QUO_W-1:0] quo_i,
  input  logic [SB_W-1:0]  sb_i,
  output logic             vld_o,
  output logic [REM_W-1:0] rem_o,
  output logic [DVS_W-1:0] dvs_o,
  output logic [QUO_W-1:0] quo_o,
  output logic [SB_W-1:0]  sb_o
);

  logic [REM_W-1:0] sub_w;
  logic             ge;
  logic             vld_r;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r;
  logic [QUO_W-1:0] quo_r, quo_nxt;
  logic [SB_W-1:0]  sb_r;

  always_comb begin
    sub_w   = REM_W'(dvs_i) << STEP;
    ge      = rem_i >= sub_w;
    rem_nxt = ge ? (rem_i - sub_w) : rem_i;
    quo_nxt = quo_i | (QUO_W'(ge) << STEP);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      dvs_r <= dvs_i;
      quo_r <= quo_nxt;
      sb_r  <= sb_i;
    end
  end

  assign vld_o = vld_r;
  assign rem_o = rem_r;
  assign dvs_o = dvs_r;
  assign quo_o = quo_r;
  assign sb_o  = sb_r;

endmodule

// ===== rtl/core/fdr_sqrt_cell.sv =====
// one digit-by-digit square root cell: settles a single root bit per beat
// depends on fdr_pkg
module fdr_sqrt_cell #(
  parameter int K    = 0,
  parameter int SB_W = 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      vld_i,
  input  logic [fdr_pkg::QUO_W-1:0] v_i,
  input  logic [fdr_pkg::RES_W-1:0] res_i,
  input  logic [SB_W-1:0]           sb_i,
  output logic                      vld_o,
  output logic [fdr_pkg::QUO_W-1:0] v_o,
  output logic [fdr_pkg::RES_W-1:0] res_o,
  output logic [SB_W-1:0]           sb_o
);

  logic [fdr_pkg::RES_W-1:0] bit_w, trial;
  logic                      ge;
  logic                      vld_r;
  logic [fdr_pkg::QUO_W-1:0] v_r, v_nxt;
  logic [fdr_pkg::RES_W-1:0] res_r, res_nxt;
  logic [SB_W-1:0]           sb_r;

  always_comb begin
    bit_w   = fdr_pkg::RES_W'(1) << (2 * K);
    trial   = res_i + bit_w;
    ge      = fdr_pkg::RES_W'(v_i) >= trial;
    v_nxt   = ge ? (v_i - trial[fdr_pkg::QUO_W-1:0]) : v_i;
    res_nxt = ge ? ((res_i >> 1) + bit_w) : (res_i >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r   <= v_nxt;
      res_r <= res_nxt;
      sb_r  <= sb_i;
    end
  end

  assign vld_o = vld_r;
  assign v_o   = v_r;
  assign res_o = res_r;
  assign sb_o  = sb_r;

endmodule

// ===== rtl/core/fresnel_dielectric_reflectance.sv =====
// throughput: one beat per cycle while the skid slot is empty, set by the rows of one-bit divide and root cells
// 4 front stages, 31 divide cells, 16 root cells, 2 product stages,
// two rows of 31 ratio divide cells, 1 square stage, output register with skid slot
// reset (rst_n, synchronous) empties the pipeline and sets both indices to 1.0
module fresnel_dielectric_reflectance (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [16:0] cos_incident
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] reflectance
  output logic [0:0]  out_tuser   // [0] total_internal
);

  localparam int DSTEPS = fdr_pkg::QUO_W;
  localparam int RSTEPS = fdr_pkg::SQRT_STEPS;

  logic en;

  // configuration
  logic [fdr_pkg::ETA_W-1:0] eta_inc_r, eta_trn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eta_inc_r <= 16'd4096;
      eta_trn_r <= 16'd4096;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        fdr_pkg::REG_ETA_INC: eta_inc_r <= cfg_wdata;
        fdr_pkg::REG_ETA_TRN: eta_trn_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stage 1: clamp, direction, swap
  logic signed [fdr_pkg::COS_W-1:0] cos_w, cos_cl;
  logic [fdr_pkg::COS_W-1:0]        neg_w;
  logic                             leave;
  fdr_pkg::fdr_geo_t                g1_nxt, g1_r, g2_r, g3_r, g4_r;
  logic                             v1_r, v2_r, v3_r, v4_r;

  always_comb begin
    cos_w  = in_tdata[fdr_pkg::COS_W-1:0];
    cos_cl = (cos_w > 17'sd32768) ? 17'sd32768 :
             ((cos_w < -17'sd32768) ? -17'sd32768 : cos_w);
    leave  = cos_cl <= 17'sd0;
    neg_w  = 17'(-cos_cl);
    g1_nxt.tir = 1'b0;
    g1_nxt.ni  = leave ? eta_trn_r : eta_inc_r;
    g1_nxt.nt  = leave ? eta_inc_r : eta_trn_r;
    g1_nxt.c   = leave ? neg_w[fdr_pkg::C_W-1:0] : cos_cl[fdr_pkg::C_W-1:0];
  end

  // stages 2 to 4: squares, sin^2 products, transmitted cos^2 dividend, total internal reflection test
  logic [fdr_pkg::PROD_W-1:0] cc_w;
  logic [fdr_pkg::S2_W-1:0]   s2_r;
  logic [fdr_pkg::PROD_W-1:0] ni_sq_r, nt_sq2_r, nt_sq3_r;
  logic [62:0]                lhs_full;
  logic [fdr_pkg::NUM_W-1:0]  lhs_r, rhs_w, num_r;
  logic [fdr_pkg::PROD_W-1:0] nt_sq4_r;

  always_comb begin
    cc_w     = g1_r.c * g1_r.c;
    lhs_full = 63'(ni_sq_r) * 63'(s2_r);
    rhs_w    = {nt_sq3_r, 30'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g1_r     <= g1_nxt;
      s2_r     <= 31'(32'h4000_0000 - cc_w);
      ni_sq_r  <= g1_r.ni * g1_r.ni;
      nt_sq2_r <= g1_r.nt * g1_r.nt;
      g2_r     <= g1_r;
      lhs_r    <= lhs_full[fdr_pkg::NUM_W-1:0];
      nt_sq3_r <= nt_sq2_r;
      g3_r     <= g2_r;
      num_r    <= rhs_w - lhs_r;
      nt_sq4_r <= nt_sq3_r;
      g4_r     <= '{tir: (lhs_r >= rhs_w), ni: g3_r.ni, nt: g3_r.nt, c: g3_r.c};
    end
  end

  // transmitted cos^2 by long division
  logic                       dv_vld [0:DSTEPS];
  logic [fdr_pkg::NUM_W-1:0]  dv_rem [0:DSTEPS];
  logic [fdr_pkg::PROD_W-1:0] dv_dvs [0:DSTEPS];
  logic [fdr_pkg::QUO_W-1:0]  dv_quo [0:DSTEPS];
  logic [fdr_pkg::GEO_W-1:0]  dv_sb  [0:DSTEPS];

  assign dv_vld[0] = v4_r;
  assign dv_rem[0] = num_r;
  assign dv_dvs[0] = nt_sq4_r;
  assign dv_quo[0] = '0;
  assign dv_sb[0]  = g4_r;

  for (genvar j = 0; j < DSTEPS; j++) begin : g_div
    fdr_div_cell #(
      .REM_W(fdr_pkg::NUM_W), .DVS_W(fdr_pkg::PROD_W), .QUO_W(fdr_pkg::QUO_W),
      .SB_W(fdr_pkg::GEO_W), .STEP(DSTEPS - 1 - j)
    ) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .vld_i(dv_vld[j]), .rem_i(dv_rem[j]), .dvs_i(dv_dvs[j]),
      .quo_i(dv_quo[j]), .sb_i(dv_sb[j]),
      .vld_o(dv_vld[j+1]), .rem_o(dv_rem[j+1]), .dvs_o(dv_dvs[j+1]),
      .quo_o(dv_quo[j+1]), .sb_o(dv_sb[j+1])
    );
  end

  // transmitted cosine by square root
  logic                      sq_vld [0:RSTEPS];
  logic [fdr_pkg::QUO_W-1:0] sq_v   [0:RSTEPS];
  logic [fdr_pkg::RES_W-1:0] sq_res [0:RSTEPS];
  logic [fdr_pkg::GEO_W-1:0] sq_sb  [0:RSTEPS];

  assign sq_vld[0] = dv_vld[DSTEPS];
  assign sq_v[0]   = dv_quo[DSTEPS];
  assign sq_res[0] = '0;
  assign sq_sb[0]  = dv_sb[DSTEPS];

  for (genvar k = 0; k < RSTEPS; k++) begin : g_sqrt
    fdr_sqrt_cell #(.K(RSTEPS - 1 - k), .SB_W(fdr_pkg::GEO_W)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .vld_i(sq_vld[k]), .v_i(sq_v[k]), .res_i(sq_res[k]), .sb_i(sq_sb[k]),
      .vld_o(sq_vld[k+1]), .v_o(sq_v[k+1]), .res_o(sq_res[k+1]), .sb_o(sq_sb[k+1])
    );
  end

  // amplitude ratio terms
  fdr_pkg::fdr_geo_t          gs_w;
  logic [fdr_pkg::C_W-1:0]    ct_w;
  logic                       p1_vld_r, p2_vld_r, p1_tir_r, p2_tir_r;
  logic [fdr_pkg::PROD_W-1:0] a_r, b_r, p_r, q_r;
  logic [fdr_pkg::PROD_W-1:0] den1_w, den2_w, num1_w, num2_w;
  logic [fdr_pkg::PROD_W-1:0] den1_r, den2_r;
  logic [fdr_pkg::RDD_W-1:0]  dd1_r, dd2_r;
  logic                       z1_r, z2_r;

  always_comb begin
    gs_w   = sq_sb[RSTEPS];
    ct_w   = sq_res[RSTEPS][fdr_pkg::C_W-1:0];
    den1_w = a_r + b_r;
    den2_w = p_r + q_r;
    num1_w = (a_r >= b_r) ? (a_r - b_r) : (b_r - a_r);
    num2_w = (p_r >= q_r) ? (p_r - q_r) : (q_r - p_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
    end else if (en) begin
      p1_vld_r <= sq_vld[RSTEPS];
      p2_vld_r <= p1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r      <= gs_w.nt * gs_w.c;
      b_r      <= gs_w.ni * ct_w;
      p_r      <= gs_w.ni * gs_w.c;
      q_r      <= gs_w.nt * ct_w;
      p1_tir_r <= gs_w.tir;
      den1_r   <= den1_w;
      den2_r   <= den2_w;
      dd1_r    <= 63'({num1_w, 30'b0}) + 63'(den1_w >> 1);
      dd2_r    <= 63'({num2_w, 30'b0}) + 63'(den2_w >> 1);
      z1_r     <= den1_w == '0;
      z2_r     <= den2_w == '0;
      p2_tir_r <= p1_tir_r;
    end
  end

  // ratio division rows, parallel and perpendicular
  logic                       ra_vld [0:DSTEPS];
  logic [fdr_pkg::RDD_W-1:0]  ra_rem [0:DSTEPS];
  logic [fdr_pkg::PROD_W-1:0] ra_dvs [0:DSTEPS];
  logic [fdr_pkg::QUO_W-1:0]  ra_quo [0:DSTEPS];
  logic [1:0]                 ra_sb  [0:DSTEPS];
  logic                       rb_vld [0:DSTEPS];
  logic [fdr_pkg::RDD_W-1:0]  rb_rem [0:DSTEPS];
  logic [fdr_pkg::PROD_W-1:0] rb_dvs [0:DSTEPS];
  logic [fdr_pkg::QUO_W-1:0]  rb_quo [0:DSTEPS];
  logic [0:0]                 rb_sb  [0:DSTEPS];

  assign ra_vld[0] = p2_vld_r;
  assign ra_rem[0] = dd1_r;
  assign ra_dvs[0] = den1_r;
  assign ra_quo[0] = '0;
  assign ra_sb[0]  = {p2_tir_r, z1_r};
  assign rb_vld[0] = p2_vld_r;
  assign rb_rem[0] = dd2_r;
  assign rb_dvs[0] = den2_r;
  assign rb_quo[0] = '0;
  assign rb_sb[0]  = z2_r;

  for (genvar j = 0; j < DSTEPS; j++) begin : g_ratio
    fdr_div_cell #(
      .REM_W(fdr_pkg::RDD_W), .DVS_W(fdr_pkg::PROD_W), .QUO_W(fdr_pkg::QUO_W),
      .SB_W(2), .STEP(DSTEPS - 1 - j)
    ) u_par (
      .clk(clk), .rst_n(rst_n), .en(en),
      .vld_i(ra_vld[j]), .rem_i(ra_rem[j]), .dvs_i(ra_dvs[j]),
      .quo_i(ra_quo[j]), .sb_i(ra_sb[j]),
      .vld_o(ra_vld[j+1]), .rem_o(ra_rem[j+1]), .dvs_o(ra_dvs[j+1]),
      .quo_o(ra_quo[j+1]), .sb_o(ra_sb[j+1])
    );
    fdr_div_cell #(
      .REM_W(fdr_pkg::RDD_W), .DVS_W(fdr_pkg::PROD_W), .QUO_W(fdr_pkg::QUO_W),
      .SB_W(1), .STEP(DSTEPS - 1 - j)
    ) u_perp (
      .clk(clk), .rst_n(rst_n), .en(en),
      .vld_i(rb_vld[j]), .rem_i(rb_rem[j]), .dvs_i(rb_dvs[j]),
      .quo_i(rb_quo[j]), .sb_i(rb_sb[j]),
      .vld_o(rb_vld[j+1]), .rem_o(rb_rem[j+1]), .dvs_o(rb_dvs[j+1]),
      .quo_o(rb_quo[j+1]), .sb_o(rb_sb[j+1])
    );
  end

  // squares of the ratios
  logic [fdr_pkg::QUO_W-1:0] r1_w, r2_w;
  logic [61:0]               sq1_full, sq2_full;
  logic                      q1_vld_r, q1_tir_r;
  logic [fdr_pkg::SQR_W-1:0] sq1_r, sq2_r;

  always_comb begin
    r1_w     = ra_sb[DSTEPS][0] ? fdr_pkg::ONE_Q30 : ra_quo[DSTEPS];
    r2_w     = rb_sb[DSTEPS][0] ? fdr_pkg::ONE_Q30 : rb_quo[DSTEPS];
    sq1_full = 62'(r1_w) * 62'(r1_w);
    sq2_full = 62'(r2_w) * 62'(r2_w);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q1_vld_r <= 1'b0;
    end else if (en) begin
      q1_vld_r <= ra_vld[DSTEPS] && rb_vld[DSTEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq1_r    <= sq1_full[fdr_pkg::SQR_W-1:0];
      sq2_r    <= sq2_full[fdr_pkg::SQR_W-1:0];
      q1_tir_r <= ra_sb[DSTEPS][1];
    end
  end

  // mean, rounding, saturation
  logic [61:0]                sum_w;
  logic [fdr_pkg::REFL_W-1:0] mean_w, refl_w;
  logic                       push;

  always_comb begin
    sum_w  = 62'(sq1_r) + 62'(sq2_r) + (62'(1) << 45);
    mean_w = sum_w[61:46];
    if (q1_tir_r || (mean_w > fdr_pkg::ONE_Q15)) begin
      refl_w = fdr_pkg::ONE_Q15;
    end else begin
      refl_w = mean_w;
    end
    push = en && q1_vld_r;
  end

  // output register and skid slot
  logic                       out_valid_r, skid_full_r;
  logic [fdr_pkg::REFL_W-1:0] out_refl_r, skid_refl_r;
  logic                       out_tir_r, skid_tir_r;

  assign en = !skid_full_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= skid_full_r || push;
      skid_full_r <= 1'b0;
    end else if (push) begin
      skid_full_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      out_refl_r <= skid_full_r ? skid_refl_r : refl_w;
      out_tir_r  <= skid_full_r ? skid_tir_r : q1_tir_r;
    end else if (push) begin
      skid_refl_r <= refl_w;
      skid_tir_r  <= q1_tir_r;
    end
  end

  assign in_tready  = en;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_refl_r;
  assign out_tuser  = out_tir_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_full_r |-> out_valid_r)
    else $error("skid slot filled while output register empty");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_full_r) |-> $past(out_valid_r && !out_tready))
    else $error("skid slot filled without an output stall");

  a_tir_is_one: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata == fdr_pkg::ONE_Q15))
    else $error("total internal reflection beat without unit reflectance");

  a_refl_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata <= fdr_pkg::ONE_Q15))
    else $error("reflectance above one");

endmodule
